### hdl/obbdf_pkg.sv
// ----------------------------------------------------------------------------
// obbdf_pkg
// Shared types, codes and saturation helpers for the oriented box decoder.
// ----------------------------------------------------------------------------
package obbdf_pkg;

    localparam int MAX_CLASSES = 256;

    typedef enum logic [2:0] {
        MODE_CX    = 3'd0,
        MODE_CY    = 3'd1,
        MODE_W     = 3'd2,
        MODE_H     = 3'd3,
        MODE_SCORE = 3'd4,
        MODE_ANGLE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_X_SCALE   = 3'd1,
        REG_Y_SCALE   = 3'd2,
        REG_IMG_W     = 3'd3,
        REG_IMG_H     = 3'd4,
        REG_BOX_LIMIT = 3'd5
    } t_reg_idx;

    localparam logic [15:0] RST_THRESHOLD = 16'd16384;
    localparam logic [23:0] RST_SCALE     = 24'd65536;
    localparam logic [14:0] RST_IMG_SIZE  = 15'd640;
    localparam logic [15:0] RST_BOX_LIMIT = 16'd30000;

    typedef struct packed {
        logic [15:0] threshold;
        logic [23:0] x_scale;
        logic [23:0] y_scale;
        logic [14:0] img_w;
        logic [14:0] img_h;
        logic [15:0] box_limit;
    } t_cfg;

    // snapshot of one anchor that passed the filter
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] w;
        logic signed [23:0] h;
        logic signed [15:0] angle;
        logic [15:0]        score;
        logic [7:0]         label;
    } t_box;

    function automatic logic signed [23:0] sat_s24(input logic signed [35:0] v);
        logic signed [23:0] r;
        if (v > 36'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -36'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [22:0] sat_u23(input logic signed [35:0] v);
        logic [22:0] r;
        if (v < 36'sd0) begin
            r = '0;
        end else if (v > 36'sd8388607) begin
            r = 23'h7FFFFF;
        end else begin
            r = v[22:0];
        end
        return r;
    endfunction

endpackage

### hdl/obbdf_cfg_regs.sv
// ----------------------------------------------------------------------------
// obbdf_cfg_regs
// Configuration register file; always ready, each write is registered.
// ----------------------------------------------------------------------------
module obbdf_cfg_regs import obbdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.x_scale   <= RST_SCALE;
            r_cfg.y_scale   <= RST_SCALE;
            r_cfg.img_w     <= RST_IMG_SIZE;
            r_cfg.img_h     <= RST_IMG_SIZE;
            r_cfg.box_limit <= RST_BOX_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[15:0];
                REG_X_SCALE:   r_cfg.x_scale   <= i_cfg_data;
                REG_Y_SCALE:   r_cfg.y_scale   <= i_cfg_data;
                REG_IMG_W:     r_cfg.img_w     <= i_cfg_data[14:0];
                REG_IMG_H:     r_cfg.img_h     <= i_cfg_data[14:0];
                REG_BOX_LIMIT: r_cfg.box_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

### hdl/obbdf_accum.sv
// ----------------------------------------------------------------------------
// obbdf_accum
// Holds box channels, tracks best class score, decides emission and limit,
// and registers a snapshot of each emitted anchor.
// ----------------------------------------------------------------------------
module obbdf_accum import obbdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [23:0] i_channel_value,
    input  logic        i_frame_start,
    output logic        o_box_valid,
    input  logic        i_box_ready,
    output t_box        o_box
);

    logic signed [23:0] r_cx, r_cy, r_w, r_h;
    logic signed [23:0] n_cx, n_cy, n_w, n_h;
    logic [15:0] r_best, n_best;
    logic [7:0]  r_label, n_label;
    logic [7:0]  r_idx, n_idx;
    logic        r_saw, n_saw;
    logic [16:0] r_count, n_count;
    logic        r_limit, n_limit;
    logic        r_bv, n_bv;
    t_box        r_box, n_box;

    logic        ready, accept, emit;
    logic [15:0] score_sat;
    logic signed [15:0] angle_sat;
    logic signed [23:0] v;

    assign v          = $signed(i_channel_value);
    assign ready      = !r_bv || i_box_ready;
    assign accept     = i_in_valid && ready;
    assign o_in_stall = !ready;
    assign o_box_valid = r_bv;
    assign o_box       = r_box;

    always_comb begin
        if (v[23]) begin
            score_sat = '0;
        end else if (|v[22:16]) begin
            score_sat = 16'hFFFF;
        end else begin
            score_sat = v[15:0];
        end
        if (!v[23] && (|v[22:15])) begin
            angle_sat = 16'sh7FFF;
        end else if (v[23] && !(&v[22:15])) begin
            angle_sat = 16'sh8000;
        end else begin
            angle_sat = v[15:0];
        end
    end

    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_best  = r_best;
        n_label = r_label;
        n_idx   = r_idx;
        n_saw   = r_saw;
        n_count = r_count;
        n_limit = r_limit;
        n_box   = r_box;
        emit    = 1'b0;
        n_bv    = i_box_ready ? 1'b0 : r_bv;
        if (accept) begin
            if (i_frame_start) begin
                n_count = '0;
                n_limit = 1'b0;
                n_best  = '0;
                n_label = '0;
                n_idx   = '0;
                n_saw   = 1'b0;
            end
            unique case (t_mode'(i_mode))
                MODE_CX: n_cx = v;
                MODE_CY: n_cy = v;
                MODE_W:  n_w  = v;
                MODE_H:  n_h  = v;
                MODE_SCORE: begin
                    if (!n_saw) begin
                        n_saw   = 1'b1;
                        n_idx   = '0;
                        n_best  = score_sat;
                        n_label = '0;
                    end else if (n_idx < 8'(MAX_CLASSES - 1)) begin
                        n_idx = n_idx + 8'd1;
                        if (score_sat > n_best) begin
                            n_best  = score_sat;
                            n_label = n_idx;
                        end
                    end
                end
                MODE_ANGLE: begin
                    emit = n_saw && (n_best >= i_cfg.threshold) && !n_limit;
                    n_box.cx    = r_cx;
                    n_box.cy    = r_cy;
                    n_box.w     = r_w;
                    n_box.h     = r_h;
                    n_box.angle = angle_sat;
                    n_box.score = n_best;
                    n_box.label = n_label;
                    if (emit) begin
                        n_count = n_count + 17'd1;
                        if (n_count > {1'b0, i_cfg.box_limit}) begin
                            n_limit = 1'b1;
                        end
                        n_bv = 1'b1;
                    end
                    n_best  = '0;
                    n_label = '0;
                    n_idx   = '0;
                    n_saw   = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_best  <= '0;
            r_label <= '0;
            r_idx   <= '0;
            r_saw   <= 1'b0;
            r_count <= '0;
            r_limit <= 1'b0;
            r_bv    <= 1'b0;
        end else begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_w     <= n_w;
            r_h     <= n_h;
            r_best  <= n_best;
            r_label <= n_label;
            r_idx   <= n_idx;
            r_saw   <= n_saw;
            r_count <= n_count;
            r_limit <= n_limit;
            r_bv    <= n_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_box <= n_box;
        end
    end

endmodule

### hdl/obbdf_scale.sv
// ----------------------------------------------------------------------------
// obbdf_scale
// Product stage, then round / corner / clamp stage into the output register.
// ----------------------------------------------------------------------------
module obbdf_scale import obbdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_box_valid,
    output logic               o_box_ready,
    input  t_box               i_box,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [22:0]        o_left,
    output logic [22:0]        o_top,
    output logic signed [23:0] o_right,
    output logic signed [23:0] o_bottom,
    output logic signed [23:0] o_center_x,
    output logic signed [23:0] o_center_y,
    output logic signed [23:0] o_box_width,
    output logic signed [23:0] o_box_height,
    output logic signed [15:0] o_angle,
    output logic [15:0]        o_score,
    output logic [7:0]         o_label
);

    // product stage
    logic               r_pv;
    logic signed [50:0] r_px1, r_py1;
    logic signed [48:0] r_pw, r_ph, r_pcx, r_pcy;
    logic signed [15:0] r_angle;
    logic [15:0]        r_score;
    logic [7:0]         r_label;

    logic out_ready, p_ready, p_load, o_load;
    logic signed [25:0] dx, dy;
    logic signed [24:0] xs, ys;

    logic signed [51:0] tx1, ty1;
    logic signed [49:0] tw, th, tcx, tcy;
    logic signed [35:0] x1, y1, bw, bh, cx, cy, x2, y2, xmax, ymax;
    logic signed [16:0] wm1, hm1;

    logic r_ov;

    assign out_ready   = !r_ov || !i_out_stall;
    assign p_ready     = !r_pv || out_ready;
    assign o_box_ready = p_ready;
    assign p_load      = i_box_valid && p_ready;
    assign o_load      = r_pv && out_ready;
    assign o_out_valid = r_ov;

    assign dx = $signed({i_box.cx[23], i_box.cx, 1'b0}) - $signed({{2{i_box.w[23]}}, i_box.w});
    assign dy = $signed({i_box.cy[23], i_box.cy, 1'b0}) - $signed({{2{i_box.h[23]}}, i_box.h});
    assign xs = $signed({1'b0, i_cfg.x_scale});
    assign ys = $signed({1'b0, i_cfg.y_scale});

    always_ff @(posedge i_clk) begin
        if (p_load) begin
            r_px1   <= dx * xs;
            r_py1   <= dy * ys;
            r_pw    <= i_box.w * xs;
            r_ph    <= i_box.h * ys;
            r_pcx   <= i_box.cx * xs;
            r_pcy   <= i_box.cy * ys;
            r_angle <= i_box.angle;
            r_score <= i_box.score;
            r_label <= i_box.label;
        end
    end

    // round half up = floor of value plus half
    always_comb begin
        tx1  = $signed({r_px1[50], r_px1}) + 52'sd65536;
        ty1  = $signed({r_py1[50], r_py1}) + 52'sd65536;
        tw   = $signed({r_pw[48], r_pw}) + 50'sd32768;
        th   = $signed({r_ph[48], r_ph}) + 50'sd32768;
        tcx  = $signed({r_pcx[48], r_pcx}) + 50'sd32768;
        tcy  = $signed({r_pcy[48], r_pcy}) + 50'sd32768;
        x1   = 36'($signed(tx1[51:17]));
        y1   = 36'($signed(ty1[51:17]));
        bw   = 36'($signed(tw[49:16]));
        bh   = 36'($signed(th[49:16]));
        cx   = 36'($signed(tcx[49:16]));
        cy   = 36'($signed(tcy[49:16]));
        wm1  = $signed({2'b00, i_cfg.img_w}) - 17'sd1;
        hm1  = $signed({2'b00, i_cfg.img_h}) - 17'sd1;
        xmax = 36'($signed({wm1, 8'd0}));
        ymax = 36'($signed({hm1, 8'd0}));
        x2   = x1 + bw;
        y2   = y1 + bh;
        if (x2 > xmax) begin
            x2 = xmax;
        end
        if (y2 > ymax) begin
            y2 = ymax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_left       <= sat_u23(x1);
            o_top        <= sat_u23(y1);
            o_right      <= sat_s24(x2);
            o_bottom     <= sat_s24(y2);
            o_center_x   <= sat_s24(cx);
            o_center_y   <= sat_s24(cy);
            o_box_width  <= sat_s24(bw);
            o_box_height <= sat_s24(bh);
            o_angle      <= r_angle;
            o_score      <= r_score;
            o_label      <= r_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (p_load) begin
                r_pv <= 1'b1;
            end else if (out_ready) begin
                r_pv <= 1'b0;
            end
            if (o_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

### hdl/oriented_box_decode_filter_core.sv
// ----------------------------------------------------------------------------
// oriented_box_decode_filter_core
// Decodes streamed detector channel words into scaled, clamped oriented boxes.
// ----------------------------------------------------------------------------
// Input channel: one channel word per cycle (i_in_valid / o_in_stall), per
// anchor in the order cx, cy, w, h, class scores, angle; i_frame_start marks
// the first word of a frame. Only an angle word whose best score passes the
// threshold, with the frame limit not yet exceeded, produces a box word on
// the output channel (o_out_valid / i_out_stall).
// Pipeline: the filter register loads on the edge that accepts the angle
// word, then the multiply and output registers follow in turn.
// Throughput is one word per cycle while o_in_stall is low; the product
// stage holds two 26x25 and four 24x25 multipliers. While the
// receiver stalls, the pipeline keeps absorbing words until the output,
// product and filter registers all hold boxes; then o_in_stall rises. Words
// that emit nothing are taken regardless as long as the filter register is
// free or draining.
// Reset (synchronous, active low) restores the register defaults, clears
// the held box, class accumulators and emitted count, and empties the
// pipeline. Configuration writes are taken every cycle and must be made
// while the block is idle.
// ----------------------------------------------------------------------------
module oriented_box_decode_filter_core import obbdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic [23:0]        i_channel_value,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [22:0]        o_left,
    output logic [22:0]        o_top,
    output logic signed [23:0] o_right,
    output logic signed [23:0] o_bottom,
    output logic signed [23:0] o_center_x,
    output logic signed [23:0] o_center_y,
    output logic signed [23:0] o_box_width,
    output logic signed [23:0] o_box_height,
    output logic signed [15:0] o_angle,
    output logic [15:0]        o_score,
    output logic [7:0]         o_label
);

    t_cfg cfg;
    t_box box;
    logic box_valid, box_ready;

    obbdf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    obbdf_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_channel_value (i_channel_value),
        .i_frame_start   (i_frame_start),
        .o_box_valid     (box_valid),
        .i_box_ready     (box_ready),
        .o_box           (box)
    );

    obbdf_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_box_valid  (box_valid),
        .o_box_ready  (box_ready),
        .i_box        (box),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_left       (o_left),
        .o_top        (o_top),
        .o_right      (o_right),
        .o_bottom     (o_bottom),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .o_angle      (o_angle),
        .o_score      (o_score),
        .o_label      (o_label)
    );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for oriented_box_decode_filter_core: streams anchors of
// channel words through the block under random idling and stalls and checks
// every box word against a cycle-free predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    import obbdf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASE_WORDS = 135;
    localparam int RAND_PHASES = 8;

    // modes the block must ignore
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] value;
        logic        frame_start;
    } t_word;

    typedef struct packed {
        logic [22:0]        left;
        logic [22:0]        top;
        logic signed [23:0] right;
        logic signed [23:0] bottom;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic signed [23:0] box_width;
        logic signed [23:0] box_height;
        logic signed [15:0] angle;
        logic [15:0]        score;
        logic [7:0]         label;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_mode = '0;
    logic [23:0]        i_channel_value = '0;
    logic               i_frame_start = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [22:0]        o_left;
    logic [22:0]        o_top;
    logic signed [23:0] o_right;
    logic signed [23:0] o_bottom;
    logic signed [23:0] o_center_x;
    logic signed [23:0] o_center_y;
    logic signed [23:0] o_box_width;
    logic signed [23:0] o_box_height;
    logic signed [15:0] o_angle;
    logic [15:0]        o_score;
    logic [7:0]         o_label;

    oriented_box_decode_filter_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_channel_value (i_channel_value),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left          (o_left),
        .o_top           (o_top),
        .o_right         (o_right),
        .o_bottom        (o_bottom),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_box_width     (o_box_width),
        .o_box_height    (o_box_height),
        .o_angle         (o_angle),
        .o_score         (o_score),
        .o_label         (o_label)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------
    t_cfg        model_cfg = '{threshold: RST_THRESHOLD, x_scale: RST_SCALE,
                               y_scale: RST_SCALE, img_w: RST_IMG_SIZE,
                               img_h: RST_IMG_SIZE, box_limit: RST_BOX_LIMIT};
    logic [15:0] top_score = '0;
    logic [7:0]  top_label = '0;
    logic [7:0]  cls_idx = '0;
    bit          seen_class = 1'b0;
    longint      hold_cx = 0, hold_cy = 0, hold_w = 0, hold_h = 0;
    logic [16:0] emit_count = '0;
    bit          limit_hit = 1'b0;

    t_word   words_to_send[$];
    t_result boxes_due[$];

    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    words_queued = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    bit    next_frame_start = 1'b0;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor((v + 2^(k-1)) / 2^k)
    function automatic longint round_shift(input longint v, input int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic void forget_classes();
        top_score  = '0;
        top_label  = '0;
        cls_idx    = '0;
        seen_class = 1'b0;
    endfunction

    // Advances the predictor by one accepted word; returns 1 when a box is due.
    function automatic bit decode_word(input logic [2:0] md, input logic signed [23:0] val,
                                       input logic fs, output t_result bx);
        longint      v, s, xs, ys, x1, y1, bw, bh, x2, y2, xmax, ymax;
        logic [15:0] sc;
        logic [7:0]  lb;
        bit          go;
        v  = val;
        bx = '0;
        if (fs) begin
            emit_count = '0;
            limit_hit  = 1'b0;
            forget_classes();
        end
        case (md)
            MODE_CX: hold_cx = v;
            MODE_CY: hold_cy = v;
            MODE_W:  hold_w  = v;
            MODE_H:  hold_h  = v;
            MODE_SCORE: begin
                s = clip(v, 0, 65535);
                if (!seen_class) begin
                    seen_class = 1'b1;
                    cls_idx    = '0;
                    top_score  = s[15:0];
                    top_label  = '0;
                end else if (cls_idx < MAX_CLASSES - 1) begin
                    cls_idx = cls_idx + 8'd1;
                    if (s > top_score) begin
                        top_score = s[15:0];
                        top_label = cls_idx;
                    end
                end
            end
            MODE_ANGLE: begin
                go = seen_class && top_score >= model_cfg.threshold && !limit_hit;
                sc = top_score;
                lb = top_label;
                forget_classes();
                if (!go) return 1'b0;
                xs   = model_cfg.x_scale;
                ys   = model_cfg.y_scale;
                x1   = round_shift((2 * hold_cx - hold_w) * xs, 17);
                y1   = round_shift((2 * hold_cy - hold_h) * ys, 17);
                bw   = round_shift(hold_w * xs, 16);
                bh   = round_shift(hold_h * ys, 16);
                x2   = x1 + bw;
                y2   = y1 + bh;
                xmax = (longint'(model_cfg.img_w) - 1) * 256;
                ymax = (longint'(model_cfg.img_h) - 1) * 256;
                if (x2 > xmax) x2 = xmax;
                if (y2 > ymax) y2 = ymax;
                bx.left       = 23'(clip(x1, 0, 8388607));
                bx.top        = 23'(clip(y1, 0, 8388607));
                bx.right      = 24'(clip(x2, -8388608, 8388607));
                bx.bottom     = 24'(clip(y2, -8388608, 8388607));
                bx.center_x   = 24'(clip(round_shift(hold_cx * xs, 16), -8388608, 8388607));
                bx.center_y   = 24'(clip(round_shift(hold_cy * ys, 16), -8388608, 8388607));
                bx.box_width  = 24'(clip(bw, -8388608, 8388607));
                bx.box_height = 24'(clip(bh, -8388608, 8388607));
                bx.angle      = 16'(clip(v, -32768, 32767));
                bx.score      = sc;
                bx.label      = lb;
                emit_count = emit_count + 17'd1;
                if (emit_count > model_cfg.box_limit) limit_hit = 1'b1;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got_v,
                               input logic signed [63:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %0d want %0d", name, got_v, want_v));
    endtask

    // ------------------------------------------------------------------
    // driver: one word per handshake from the pending queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        t_result bx;
        t_word   wd;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_word(i_mode, i_channel_value, i_frame_start, bx))
                    boxes_due = {boxes_due, bx};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    wd = words_to_send.pop_front();
                    i_in_valid      <= 1'b1;
                    i_mode          <= wd.mode;
                    i_channel_value <= wd.value;
                    i_frame_start   <= wd.frame_start;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: box words against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_boxes
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (boxes_due.size() == 0) begin
                    report_mismatch("box word with no box expected");
                end else begin
                    want = boxes_due.pop_front();
                    check_field("left", o_left, want.left);
                    check_field("top", o_top, want.top);
                    check_field("right", o_right, want.right);
                    check_field("bottom", o_bottom, want.bottom);
                    check_field("center_x", o_center_x, want.center_x);
                    check_field("center_y", o_center_y, want.center_y);
                    check_field("box_width", o_box_width, want.box_width);
                    check_field("box_height", o_box_height, want.box_height);
                    check_field("angle", o_angle, want.angle);
                    check_field("score", o_score, want.score);
                    check_field("label", o_label, want.label);
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic [2:0] md, input logic [23:0] val);
        t_word wd;
        wd.mode        = md;
        wd.value       = val;
        wd.frame_start = next_frame_start;
        next_frame_start = 1'b0;
        words_to_send = {words_to_send, wd};
        words_queued++;
    endtask

    function automatic logic [23:0] rand_coord(input bit is_size);
        case ($urandom_range(7))
            0:       return 24'($urandom);
            1:       return 24'(-int'($urandom_range(0, 200 * 256)));
            default: return is_size ? 24'($urandom_range(0, 400 * 256))
                                    : 24'($urandom_range(0, 700 * 256));
        endcase
    endfunction

    function automatic logic [23:0] rand_score(input logic [23:0] prev);
        case ($urandom_range(9))
            0:       return 24'($urandom);               // may be negative or too large
            1:       return 24'(int'(model_cfg.threshold) + int'($urandom_range(0, 4)) - 2);
            2:       return prev;                         // tie, first one wins
            default: return 24'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [23:0] rand_angle();
        if ($urandom_range(4) == 0) return 24'($urandom);
        return 24'(int'($urandom_range(0, 51472)) - 25736);
    endfunction

    // one anchor; sometimes a position word goes missing
    task automatic queue_anchor(input int n_cls);
        int          skip;
        logic [23:0] sc;
        skip = ($urandom_range(9) == 0) ? int'($urandom_range(3)) : -1;
        sc   = 24'($urandom_range(0, 65535));
        if (skip != 0) push_word(MODE_CX, rand_coord(1'b0));
        if (skip != 1) push_word(MODE_CY, rand_coord(1'b0));
        if (skip != 2) push_word(MODE_W, rand_coord(1'b1));
        if (skip != 3) push_word(MODE_H, rand_coord(1'b1));
        repeat (n_cls) begin
            sc = rand_score(sc);
            push_word(MODE_SCORE, sc);
        end
        push_word(MODE_ANGLE, rand_angle());
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        case ($urandom_range(5))
            0:       c.threshold = '0;
            1:       c.threshold = 16'hFFFF;
            default: c.threshold = 16'($urandom_range(0, 40000));
        endcase
        case ($urandom_range(7))
            0:       c.x_scale = '0;
            1:       c.x_scale = 24'hFFFFFF;
            2:       c.x_scale = 24'($urandom);
            default: c.x_scale = 24'($urandom_range(16384, 262144));
        endcase
        case ($urandom_range(7))
            0:       c.y_scale = '0;
            1:       c.y_scale = 24'hFFFFFF;
            2:       c.y_scale = 24'($urandom);
            default: c.y_scale = 24'($urandom_range(16384, 262144));
        endcase
        c.img_w = ($urandom_range(3) == 0) ? 15'd16384 : 15'($urandom_range(1, 16384));
        c.img_h = ($urandom_range(3) == 0) ? 15'd1 : 15'($urandom_range(1, 16384));
        case ($urandom_range(3))
            0:       c.box_limit = 16'hFFFF;
            default: c.box_limit = 16'($urandom_range(0, 6));
        endcase
        return c;
    endfunction

    // all six registers, valid held high across back-to-back writes
    task automatic apply_config(input t_cfg c);
        t_reg_idx idx;
        idx = idx.first();
        repeat (idx.num()) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                REG_THRESHOLD: i_cfg_data <= 24'(c.threshold);
                REG_X_SCALE:   i_cfg_data <= c.x_scale;
                REG_Y_SCALE:   i_cfg_data <= c.y_scale;
                REG_IMG_W:     i_cfg_data <= 24'(c.img_w);
                REG_IMG_H:     i_cfg_data <= 24'(c.img_h);
                default:       i_cfg_data <= 24'(c.box_limit);
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
        model_cfg = c;
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || i_in_valid || boxes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("oriented_box_decode_filter_core verification failed");
        $finish;
    end

    initial begin : run_phases
        t_cfg c;
        int   goal;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration (threshold 0.25)
        next_frame_start = 1'b1;
        push_word(MODE_CX, 24'd25600);
        push_word(MODE_CY, 24'd20480);
        push_word(MODE_W, 24'd10240);
        push_word(MODE_H, 24'd7680);
        push_word(MODE_SCORE, 24'd1000);
        push_word(MODE_SCORE, 24'd30000);
        push_word(MODE_SCORE, 24'd30000);           // tie keeps the earlier class
        push_word(MODE_SCORE, 24'd200);
        push_word(MODE_ANGLE, 24'd1234);
        push_word(MODE_SCORE, -24'sd5);             // scores saturate both ways
        push_word(MODE_SCORE, 24'd70000);
        push_word(MODE_ANGLE, 24'h800000);          // angle saturates low
        push_word(MODE_CX, 24'h7FFFFF);
        push_word(MODE_CY, 24'h800000);
        push_word(MODE_W, 24'h800000);
        push_word(MODE_H, 24'h7FFFFF);
        push_word(MODE_SCORE, 24'd65535);
        push_word(MODE_ANGLE, 24'h7FFFFF);
        push_word(MODE_ANGLE, 24'd0);               // no class seen
        push_word(MODE_SPARE_6, 24'($urandom));
        push_word(MODE_SPARE_7, 24'($urandom));
        push_word(MODE_SCORE, 24'd100);             // below threshold
        push_word(MODE_ANGLE, 24'd77);
        push_word(MODE_SCORE, 24'(RST_THRESHOLD));  // exactly at threshold
        push_word(MODE_ANGLE, 24'd5);
        wait_drained();

        for (int p = 1; p <= RAND_PHASES; p++) begin
            if (p == 1) begin
                c = '{threshold: 16'd0, x_scale: RST_SCALE, y_scale: RST_SCALE,
                      img_w: RST_IMG_SIZE, img_h: RST_IMG_SIZE, box_limit: 16'hFFFF};
            end else if (p == 2) begin
                c = '{threshold: 16'hFFFF, x_scale: 24'hFFFFFF, y_scale: 24'd0,
                      img_w: 15'd1, img_h: 15'd16384, box_limit: 16'd0};
            end else begin
                c = random_config();
            end
            apply_config(c);
            case ((p - 1) % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase

            if (p == 1) begin
                // more classes than the block tracks; the tail must be ignored
                push_word(MODE_CX, rand_coord(1'b0));
                push_word(MODE_CY, rand_coord(1'b0));
                push_word(MODE_W, rand_coord(1'b1));
                push_word(MODE_H, rand_coord(1'b1));
                for (int k = 0; k < MAX_CLASSES + 4; k++)
                    push_word(MODE_SCORE, 24'(1000 + 200 * k));
                push_word(MODE_ANGLE, rand_angle());
            end

            goal = words_queued + PHASE_WORDS;
            while (words_queued < goal) begin
                if ($urandom_range(19) < 2) begin
                    next_frame_start = ($urandom_range(15) == 0);
                    push_word(3'($urandom_range(7)), 24'($urandom));
                end else begin
                    next_frame_start = ($urandom_range(7) == 0);
                    queue_anchor(($urandom_range(11) == 0) ? 0 : int'($urandom_range(1, 6)));
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("oriented_box_decode_filter_core verification clean");
        else
            $display("oriented_box_decode_filter_core verification failed");
        $finish;
    end

endmodule

### filelist.f
hdl/obbdf_pkg.sv
hdl/obbdf_cfg_regs.sv
hdl/obbdf_accum.sv
hdl/obbdf_scale.sv
hdl/oriented_box_decode_filter_core.sv
sim/tb.sv
